// ----- rtl/ciq_pkg.sv -----
// Package of types, constants and helpers shared by the countdown issue queue.
`timescale 1ns / 1ps

package ciq_pkg;

  // Queue geometry and field widths.
  localparam int DEPTH      = 16;
  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int CW         = COUNT_BITS + 1;

  // Input transaction kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_READY  = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Most negative countdown value; decrements saturate here.
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

  // One queue entry.
  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic signed [CW-1:0] half;
    logic signed [CW-1:0] full;
  } ciq_entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic             tick;
    logic             shift;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
  } ciq_ctrl_t;

  // Saturating decrement of a countdown.
  function automatic logic signed [CW-1:0] dec_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v == CNT_MIN) begin
      r = v;
    end else begin
      r = v - CW'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/ciq_cell.sv -----
// One slot of the queue chain: holds an entry and takes its neighbour's each shift.
`timescale 1ns / 1ps

module ciq_cell
  import ciq_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] my_idx,
  input  ciq_ctrl_t        ctrl,
  input  ciq_entry_t       wr_data,
  input  ciq_entry_t       nbr_data,
  output ciq_entry_t       ent,
  output logic             ready
);

  ciq_entry_t ent_r;
  ciq_entry_t ent_nxt;

  // A tick decrements both countdowns; a targeted write beats a shift.
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.tick) begin
      ent_nxt.half = dec_sat(ent_r.half);
      ent_nxt.full = dec_sat(ent_r.full);
    end else if (ctrl.wr && (ctrl.wr_idx == my_idx)) begin
      ent_nxt = wr_data;
    end else if (ctrl.shift) begin
      ent_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent   = ent_r;
  // The entry is ready once its half countdown is zero or negative.
  assign ready = ent_r.half[CW-1] | (ent_r.half == '0);

endmodule

// ----- rtl/countdown_issue_queue.sv -----
// Top level of the countdown issue queue: control sequencer around a chain of cells.
//
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+-----------------------------
//  input    | in_kind, in_instr_tag, in_countdown           | start high while busy low
//  result   | out_status, out_tag, out_countdown, out_last  | out_valid for one cycle
//
// An add or a tick leaves busy low, and the add's result appears in the following
// cycle. A fetch with nothing ready gives its result in the next cycle. Otherwise
// busy goes high and the chain rotates once per queued entry, one result leaving
// per ready one. Reset empties the queue; the receiver cannot stall the results.
`timescale 1ns / 1ps

module countdown_issue_queue
  import ciq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_kind,
  input  logic [TAG_BITS-1:0]  in_instr_tag,
  input  logic [COUNT_BITS-1:0] in_countdown,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic signed [CW-1:0] out_countdown,
  output logic                 out_last
);

  // Control registers.
  logic             busy_r, busy_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] rem_r, rem_nxt;
  logic [OCC_W-1:0] kept_r, kept_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Result payload registers.
  logic [1:0]           out_status_r, out_status_nxt;
  logic [TAG_BITS-1:0]  out_tag_r, out_tag_nxt;
  logic signed [CW-1:0] out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  ciq_ctrl_t    ctrl;
  ciq_entry_t   wr_data;
  ciq_entry_t   cell_ent [DEPTH];
  logic [DEPTH-1:0] cell_ready;
  logic         accept;
  logic [OCC_W-1:0] limit;
  logic         any_ready;
  logic         other_ready;
  logic [OCC_W-1:0] tail_pos;

  assign accept = start & ~busy_r;

  // The chain of cells; the last one takes in a blank entry on a shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ciq_entry_t nbr;
    if (i == DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_ent[i+1];
    end
    ciq_cell u_cell (
      .clk      (clk),
      .my_idx   (IDX_W'(i)),
      .ctrl     (ctrl),
      .wr_data  (wr_data),
      .nbr_data (nbr),
      .ent      (cell_ent[i]),
      .ready    (cell_ready[i])
    );
  end

  // Ready entries among those still to be examined.
  assign limit = busy_r ? rem_r : occ_r;

  always_comb begin
    any_ready   = 1'b0;
    other_ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_ready[i] && (OCC_W'(i) < limit)) begin
        any_ready = 1'b1;
        if (i != 0) begin
          other_ready = 1'b1;
        end
      end
    end
  end

  // A kept entry goes behind the survivors, after the unexamined ones.
  assign tail_pos = rem_r - OCC_W'(1) + kept_r;

  // Sequencer.
  always_comb begin
    busy_nxt       = busy_r;
    occ_nxt        = occ_r;
    rem_nxt        = rem_r;
    kept_nxt       = kept_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_NONE;
    out_tag_nxt    = '0;
    out_count_nxt  = '0;
    out_last_nxt   = 1'b1;
    ctrl           = '0;
    wr_data.tag    = in_instr_tag;
    wr_data.full   = CW'(in_countdown);
    wr_data.half   = CW'(in_countdown >> 1);

    if (busy_r) begin
      // One rotation step: the head leaves either as a result or to the tail.
      ctrl.shift = 1'b1;
      wr_data    = cell_ent[0];
      if (cell_ready[0]) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_READY;
        out_tag_nxt    = cell_ent[0].tag;
        out_count_nxt  = cell_ent[0].full;
        out_last_nxt   = ~other_ready;
      end else begin
        ctrl.wr     = 1'b1;
        ctrl.wr_idx = tail_pos[IDX_W-1:0];
        kept_nxt    = kept_r + OCC_W'(1);
      end
      rem_nxt = rem_r - OCC_W'(1);
      if (rem_r == OCC_W'(1)) begin
        busy_nxt = 1'b0;
        occ_nxt  = kept_nxt;
      end
    end else if (accept) begin
      case (in_kind)
        KIND_ADD: begin
          out_valid_nxt = 1'b1;
          if (occ_r == OCC_W'(DEPTH)) begin
            out_status_nxt = ST_DROP;
          end else begin
            out_status_nxt = ST_ACCEPT;
            ctrl.wr        = 1'b1;
            ctrl.wr_idx    = occ_r[IDX_W-1:0];
            occ_nxt        = occ_r + OCC_W'(1);
          end
        end
        KIND_TICK: begin
          ctrl.tick = 1'b1;
        end
        KIND_FETCH: begin
          if (any_ready) begin
            busy_nxt = 1'b1;
            rem_nxt  = occ_r;
            kept_nxt = '0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NONE;
          end
        end
        default: begin
          // Unused kind: no state change and no result.
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      occ_r       <= '0;
      rem_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_tag       = out_tag_r;
  assign out_countdown = out_count_r;
  assign out_last      = out_last_r;

endmodule
